@@ hw/rtl/cfbs_pkg.sv @@
// shared types, codes and saturation helpers for the convective flux balance scatter core
// no dependencies

package cfbs_pkg;

  localparam int WEIGHT_BITS = 16;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic signed [63:0] RND_W = 64'sd1 <<< (WEIGHT_BITS - 1);

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic SCHEME_UPWIND = 1'b0;
  localparam logic SCHEME_LINEAR = 1'b1;

  typedef enum logic [11:0] {
    ST_CLEAR    = 12'b000000000001,
    ST_IDLE     = 12'b000000000010,
    ST_MUL_A    = 12'b000000000100,
    ST_MUL_B    = 12'b000000001000,
    ST_FACE     = 12'b000000010000,
    ST_MUL_C    = 12'b000000100000,
    ST_ROUND    = 12'b000001000000,
    ST_UPD_OWN  = 12'b000010000000,
    ST_RD_NBR   = 12'b000100000000,
    ST_UPD_NBR  = 12'b001000000000,
    ST_RD_CELL  = 12'b010000000000,
    ST_OUT_CELL = 12'b100000000000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x[63:31] == {33{x[63]}}) begin
      r = x[31:0];
    end else if (x[63]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [64:0] x);
    logic signed [47:0] r;
    if (x[64:47] == {18{x[64]}}) begin
      r = x[47:0];
    end else if (x[64]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/cfbs_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies

module cfbs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/convective_flux_balance_scatter_core.sv @@
// convective flux balance scatter core, built on cfbs_pkg and cfbs_ram
// a beat is taken only in idle; an internal face holds busy through the multiply, face,
// round, own update and neighbour read and update states, a boundary face ends after its
// own update; a read holds busy in ST_RD_CELL and ST_OUT_CELL; one 32x32 multiplier
// and the one ram read port are shared; the receiver cannot stall, so results are never held
// reset: synchronous, clears scheme_select, then ST_CLEAR zeroes every entry with busy high

module convective_flux_balance_scatter_core
  import cfbs_pkg::*;
#(
  parameter int NUM_CELLS = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [9:0]         owner_cell,
  input  logic [9:0]         neighbor_cell,
  input  logic               boundary_face,
  input  logic signed [31:0] face_flux,
  input  logic signed [31:0] owner_value,
  input  logic signed [31:0] neighbor_value,
  input  logic [16:0]        interp_weight,
  input  logic               bc_is_neumann,
  input  logic signed [31:0] bc_value,
  input  logic signed [31:0] normal_distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  output logic               result_valid,
  output logic [9:0]         cell_index,
  output logic signed [47:0] balance_value
);

  localparam int ADDR_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_CELLS - 1);
  localparam logic signed [63:0] RND_F = 64'sd1 <<< (FRAC_BITS - 1);

  state_t state, state_next;

  logic               scheme_select;
  logic               cmd;
  logic [9:0]         own_cell;
  logic [9:0]         nbr_cell;
  logic               bnd;
  logic signed [31:0] flux;
  logic signed [31:0] own_val;
  logic signed [31:0] nbr_val;
  logic [16:0]        weight;
  logic               neumann;
  logic signed [31:0] bc_val;
  logic signed [31:0] nrm_dist;

  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [31:0] face;
  logic signed [31:0] face_next;
  logic signed [63:0] contrib;
  logic [ADDR_W-1:0]  clr_cnt;

  logic               linear;
  logic               use_bc;
  logic               own_ok;
  logic               nbr_ok;
  logic [16:0]        w_clamp;
  logic [16:0]        w_rest;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] lin_sum;
  logic signed [63:0] neu_sum;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic signed [47:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic signed [47:0] ram_rdata;
  logic [ADDR_W-1:0]  own_addr;
  logic [ADDR_W-1:0]  nbr_addr;

  assign busy = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign linear = (scheme_select == SCHEME_LINEAR);
  assign use_bc = bnd && (linear || flux[31]);
  assign own_ok = 32'(own_cell) < NUM_CELLS;
  assign nbr_ok = 32'(nbr_cell) < NUM_CELLS;
  assign own_addr = ADDR_W'(own_cell);
  assign nbr_addr = ADDR_W'(nbr_cell);
  assign w_clamp = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
  assign w_rest = WEIGHT_ONE - w_clamp;

  // shared multiplier operand selection
  always_comb begin
    mul_a = flux;
    mul_b = face;
    case (state)
      ST_MUL_A: begin
        if (linear && !bnd) begin
          mul_a = own_val;
          mul_b = $signed({15'd0, w_rest});
        end else begin
          mul_a = bc_val;
          mul_b = nrm_dist;
        end
      end
      ST_MUL_B: begin
        mul_a = nbr_val;
        mul_b = $signed({15'd0, w_clamp});
      end
      default: begin
        mul_a = flux;
        mul_b = face;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // acc already carries the rounding offset
  assign lin_sum = acc + prod;
  assign neu_sum = 64'(own_val) + (acc >>> FRAC_BITS);

  always_comb begin
    if (bnd) begin
      if (use_bc) begin
        face_next = neumann ? sat32(neu_sum) : bc_val;
      end else begin
        face_next = own_val;
      end
    end else if (linear) begin
      face_next = 32'(lin_sum >>> WEIGHT_BITS);
    end else begin
      face_next = flux[31] ? nbr_val : own_val;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (clr_cnt == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          state_next = (command == CMD_READ) ? ST_RD_CELL : ST_MUL_A;
        end
      end
      ST_MUL_A:    state_next = ST_MUL_B;
      ST_MUL_B:    state_next = ST_FACE;
      ST_FACE:     state_next = ST_MUL_C;
      ST_MUL_C:    state_next = ST_ROUND;
      ST_ROUND:    state_next = ST_UPD_OWN;
      ST_UPD_OWN:  state_next = bnd ? ST_IDLE : ST_RD_NBR;
      ST_RD_NBR:   state_next = ST_UPD_NBR;
      ST_UPD_NBR:  state_next = ST_IDLE;
      ST_RD_CELL:  state_next = ST_OUT_CELL;
      ST_OUT_CELL: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // balance store port control
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = own_addr;
    ram_wdata = '0;
    ram_raddr = own_addr;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_cnt;
      end
      ST_UPD_OWN: begin
        ram_we = own_ok;
        ram_wdata = sat48(65'(ram_rdata) + 65'(contrib));
      end
      ST_RD_NBR: begin
        ram_raddr = nbr_addr;
      end
      ST_UPD_NBR: begin
        ram_we = nbr_ok;
        ram_waddr = nbr_addr;
        ram_wdata = sat48(65'(ram_rdata) - 65'(contrib));
      end
      ST_OUT_CELL: begin
        ram_we = own_ok;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  cfbs_ram #(
    .WIDTH(48),
    .DEPTH(NUM_CELLS)
  ) u_store (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      scheme_select <= SCHEME_UPWIND;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= (state == ST_OUT_CELL);
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        scheme_select <= cfg_data;
      end
    end
  end

  // beat capture and datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd <= command;
      own_cell <= owner_cell;
      nbr_cell <= neighbor_cell;
      bnd <= boundary_face;
      flux <= face_flux;
      own_val <= owner_value;
      nbr_val <= neighbor_value;
      weight <= interp_weight;
      neumann <= bc_is_neumann;
      bc_val <= bc_value;
      nrm_dist <= normal_distance;
    end
    if (state == ST_MUL_A || state == ST_MUL_B || state == ST_MUL_C) begin
      prod <= mul_p;
    end
    if (state == ST_MUL_B) begin
      acc <= prod + ((linear && !bnd) ? RND_W : RND_F);
    end
    if (state == ST_FACE) begin
      face <= face_next;
    end
    if (state == ST_ROUND) begin
      contrib <= (prod + RND_F) >>> FRAC_BITS;
    end
    if (state == ST_OUT_CELL && cmd == CMD_READ) begin
      cell_index <= own_cell;
      balance_value <= own_ok ? ram_rdata : '0;
    end
  end

endmodule

@@ hw/rtl/cfbs_checker.sv @@
// port-level checks for the convective flux balance scatter core, bound to the top level
// depends on cfbs_pkg

module cfbs_checker
  import cfbs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               command,
  input logic [9:0]         owner_cell,
  input logic               result_valid,
  input logic [9:0]         cell_index
);

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // every accepted beat occupies the core
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // a read beat returns its cell once ST_RD_CELL and ST_OUT_CELL have passed
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_READ) |->
      ##3 (result_valid && cell_index == $past(owner_cell, 3)))
    else $error("read result missing or wrong cell");

  // no result without a read beat
  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy && command == CMD_READ, 3))
    else $error("result without read beat");

endmodule

bind convective_flux_balance_scatter_core cfbs_checker u_cfbs_checker (.*);
